// ----- rtl/core/rgba8_source_over_blend_core_assert.svh -----
// -----------------------------------------------------------------------------
// Assertion macros for the source-over blend core
// Shorthands for clocked assertions that are cut off while reset is high.
// -----------------------------------------------------------------------------
`ifndef RGBA8_SOURCE_OVER_BLEND_CORE_ASSERT_SVH
`define RGBA8_SOURCE_OVER_BLEND_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RSOB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RSOB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/rsob_pkg.sv -----
// -----------------------------------------------------------------------------
// Source-over blend package
// Widths, register indexes, reset values and the 16-to-8 rounding function.
// -----------------------------------------------------------------------------
package rsob_pkg;

   localparam int unsigned CH_W        = 8;
   localparam int unsigned NUM_CH      = 4;
   localparam int unsigned OPACITY_W   = 9;
   localparam int unsigned AIDX_W      = 2;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 9;

   // Quotient pipeline: DIV_STAGES * DIV_BITS_PER_STAGE must equal CH_W
   localparam int unsigned DIV_STAGES         = 4;
   localparam int unsigned DIV_BITS_PER_STAGE = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY     = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_INDEX = 1'b1;

   localparam logic [OPACITY_W-1:0] OPACITY_RESET = 9'd256;
   localparam logic [AIDX_W-1:0]    AIDX_RESET    = 2'd3;

   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   typedef logic [CH_W-1:0]   chan_type;
   typedef logic [2*CH_W-1:0] wide_type;

   // Round a 16-bit product to 8 bits: (x + 1 + (x >> 8)) >> 8, saturating adds
   function automatic chan_type down16(input wide_type x);
      logic [16:0] s1;
      logic [15:0] s1c;
      logic [16:0] s2;
      logic [15:0] s2c;
      s1  = {1'b0, x} + 17'd1;
      s1c = s1[16] ? 16'hFFFF : s1[15:0];
      s2  = {1'b0, s1c} + {9'd0, x[15:8]};
      s2c = s2[16] ? 16'hFFFF : s2[15:0];
      return s2c[15:8];
   endfunction

endpackage

// ----- rtl/core/rsob_div.sv -----
// -----------------------------------------------------------------------------
// Blend weight divider
// Restoring divider, two quotient bits per stage, quotient saturated to 8 bits.
// -----------------------------------------------------------------------------
module rsob_div (
   input  logic                             clock,
   input  logic [rsob_pkg::DIV_STAGES-1:0]  stage_en,
   input  rsob_pkg::wide_type               dividend,
   input  rsob_pkg::chan_type               divisor,
   output rsob_pkg::chan_type               quotient
);

   localparam int unsigned NS = rsob_pkg::DIV_STAGES;

   rsob_pkg::chan_type rem_ff  [NS];
   rsob_pkg::chan_type low_ff  [NS];
   rsob_pkg::chan_type quo_ff  [NS];
   rsob_pkg::chan_type dvs_ff  [NS];
   logic               zero_ff [NS];
   logic               sat_ff  [NS];

   rsob_pkg::chan_type rem_in  [NS];
   rsob_pkg::chan_type low_in  [NS];
   rsob_pkg::chan_type quo_in  [NS];
   rsob_pkg::chan_type dvs_in  [NS];
   logic               zero_in [NS];
   logic               sat_in  [NS];

   rsob_pkg::chan_type src_rem [NS];
   rsob_pkg::chan_type src_low [NS];
   rsob_pkg::chan_type src_quo [NS];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      if (g == 0) begin : g_first
         // quotient of 256 or more shows up as high byte >= divisor
         assign src_rem[g] = dividend[15:8];
         assign src_low[g] = dividend[7:0];
         assign src_quo[g] = '0;
         assign dvs_in[g]  = divisor;
         assign zero_in[g] = (divisor == '0);
         assign sat_in[g]  = (dividend[15:8] >= divisor);
      end else begin : g_next
         assign src_rem[g] = rem_ff[g-1];
         assign src_low[g] = low_ff[g-1];
         assign src_quo[g] = quo_ff[g-1];
         assign dvs_in[g]  = dvs_ff[g-1];
         assign zero_in[g] = zero_ff[g-1];
         assign sat_in[g]  = sat_ff[g-1];
      end

      always_comb begin
         logic [8:0]         trial;
         rsob_pkg::chan_type r;
         rsob_pkg::chan_type l;
         rsob_pkg::chan_type q;
         r = src_rem[g];
         l = src_low[g];
         q = src_quo[g];
         for (int k = 0; k < rsob_pkg::DIV_BITS_PER_STAGE; k++) begin
            trial = {r, l[7]};
            l     = {l[6:0], 1'b0};
            if (trial >= {1'b0, dvs_in[g]}) begin
               r = 8'(trial - {1'b0, dvs_in[g]});
               q = {q[6:0], 1'b1};
            end else begin
               r = trial[7:0];
               q = {q[6:0], 1'b0};
            end
         end
         rem_in[g] = r;
         low_in[g] = l;
         quo_in[g] = q;
      end

      always_ff @(posedge clock) begin
         if (stage_en[g]) begin
            rem_ff[g]  <= rem_in[g];
            low_ff[g]  <= low_in[g];
            quo_ff[g]  <= quo_in[g];
            dvs_ff[g]  <= dvs_in[g];
            zero_ff[g] <= zero_in[g];
            sat_ff[g]  <= sat_in[g];
         end
      end
   end

   // zero divisor gives weight 0, overflow clamps to full weight
   assign quotient = zero_ff[NS-1] ? '0 :
                     sat_ff[NS-1]  ? rsob_pkg::CH_MAX : quo_ff[NS-1];

endmodule

// ----- rtl/core/rgba8_source_over_blend_core.sv -----
// -----------------------------------------------------------------------------
// RGBA8 source-over blend core
// Blends one source pixel over one backdrop pixel per request.
// -----------------------------------------------------------------------------
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   req     | in        | req_valid/req_stall  | req_src_c0..3, req_bg_c0..3
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_out_c0..3
//   csr     | in        | csr_wen              | csr_index, csr_wdata
//
// Throughput is one request per clock while req_stall is low; requests pass stages
// A, B, C, the four-stage restoring divider that forms the blend weight, E and F.
// Each stage has its own valid bit and moves on when empty or when the stage
// after it moves, so bubbles close up and a full pipeline holds everything.
// req_stall rises only when every stage is full and rsp_stall is high.
// Synchronous reset clears the valid bits, opacity to 1.0 and alpha index to 3.
// Write the CSRs only while no request is in flight.
//
`include "rgba8_source_over_blend_core_assert.svh"

module rgba8_source_over_blend_core (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rsob_pkg::chan_type                   req_src_c0,
   input  rsob_pkg::chan_type                   req_src_c1,
   input  rsob_pkg::chan_type                   req_src_c2,
   input  rsob_pkg::chan_type                   req_src_c3,
   input  rsob_pkg::chan_type                   req_bg_c0,
   input  rsob_pkg::chan_type                   req_bg_c1,
   input  rsob_pkg::chan_type                   req_bg_c2,
   input  rsob_pkg::chan_type                   req_bg_c3,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rsob_pkg::chan_type                   rsp_out_c0,
   output rsob_pkg::chan_type                   rsp_out_c1,
   output rsob_pkg::chan_type                   rsp_out_c2,
   output rsob_pkg::chan_type                   rsp_out_c3,

   input  logic                                 csr_wen,
   input  logic [rsob_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rsob_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned NC         = rsob_pkg::NUM_CH;
   localparam int unsigned NS         = rsob_pkg::DIV_STAGES;
   // stage map: scale, multiply, result alpha, divider, weight products, output
   localparam int unsigned STG_A      = 0;
   localparam int unsigned STG_B      = 1;
   localparam int unsigned STG_C      = 2;
   localparam int unsigned STG_Q      = 3;
   localparam int unsigned STG_E      = STG_Q + NS;
   localparam int unsigned STG_F      = STG_E + 1;
   localparam int unsigned NUM_STAGES = STG_F + 1;

   // --------------------------------------------------------------------------
   // Configuration registers
   // --------------------------------------------------------------------------
   logic [rsob_pkg::OPACITY_W-1:0] opacity_ff;
   logic [rsob_pkg::AIDX_W-1:0]    alpha_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff   <= rsob_pkg::OPACITY_RESET;
         alpha_idx_ff <= rsob_pkg::AIDX_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            rsob_pkg::CSR_OPACITY: begin
               opacity_ff <= csr_wdata[rsob_pkg::OPACITY_W-1:0];
            end
            rsob_pkg::CSR_ALPHA_INDEX: begin
               alpha_idx_ff <= csr_wdata[rsob_pkg::AIDX_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // Pipeline control: one valid bit per stage, ready ripples back from rsp
   // --------------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] valid_up;
   logic [NUM_STAGES-1:0] rdy;

   assign rdy[STG_F] = !valid_ff[STG_F] || !rsp_stall;
   for (genvar k = 0; k < STG_F; k++) begin : g_rdy
      assign rdy[k] = !valid_ff[k] || rdy[k+1];
   end

   assign valid_up = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_comb begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_up[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !rdy[STG_A];
   assign rsp_valid = valid_ff[STG_F];

   // --------------------------------------------------------------------------
   // Stage A: pick alpha lanes, scale source alpha by opacity
   // --------------------------------------------------------------------------
   rsob_pkg::chan_type req_src [NC];
   rsob_pkg::chan_type req_bg  [NC];

   assign req_src[0] = req_src_c0;
   assign req_src[1] = req_src_c1;
   assign req_src[2] = req_src_c2;
   assign req_src[3] = req_src_c3;
   assign req_bg[0]  = req_bg_c0;
   assign req_bg[1]  = req_bg_c1;
   assign req_bg[2]  = req_bg_c2;
   assign req_bg[3]  = req_bg_c3;

   logic [16:0]        scaled;
   rsob_pkg::chan_type as_in;

   assign scaled = 17'(req_src[alpha_idx_ff]) * 17'(opacity_ff);
   // opacity above 1.0 can push alpha past 255: clamp
   assign as_in  = scaled[16] ? rsob_pkg::CH_MAX : scaled[15:8];

   rsob_pkg::chan_type s_a_ff [NC];
   rsob_pkg::chan_type b_a_ff [NC];
   rsob_pkg::chan_type as_a_ff;
   rsob_pkg::chan_type ab_a_ff;

   always_ff @(posedge clock) begin
      if (rdy[STG_A]) begin
         s_a_ff  <= req_src;
         b_a_ff  <= req_bg;
         as_a_ff <= as_in;
         ab_a_ff <= req_bg[alpha_idx_ff];
      end
   end

   // --------------------------------------------------------------------------
   // Stage B: alpha product, source premultiply products, divider dividend
   // --------------------------------------------------------------------------
   rsob_pkg::wide_type pab_in;
   rsob_pkg::wide_type pb_in [NC];
   rsob_pkg::wide_type pc_in [NC];
   rsob_pkg::wide_type dvd_in;

   assign pab_in = 16'(as_a_ff) * 16'(ab_a_ff);
   // as * 255 as a shift and subtract
   assign dvd_in = {as_a_ff, 8'd0} - {8'd0, as_a_ff};

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         pb_in[i] = 16'(ab_a_ff) * 16'(s_a_ff[i]);
         pc_in[i] = 16'(rsob_pkg::CH_MAX - ab_a_ff) * 16'(s_a_ff[i]);
      end
   end

   rsob_pkg::wide_type pab_b_ff;
   rsob_pkg::wide_type pb_b_ff [NC];
   rsob_pkg::wide_type pc_b_ff [NC];
   rsob_pkg::wide_type dvd_b_ff;
   rsob_pkg::chan_type b_b_ff  [NC];
   rsob_pkg::chan_type as_b_ff;
   rsob_pkg::chan_type ab_b_ff;

   always_ff @(posedge clock) begin
      if (rdy[STG_B]) begin
         pab_b_ff <= pab_in;
         pb_b_ff  <= pb_in;
         pc_b_ff  <= pc_in;
         dvd_b_ff <= dvd_in;
         b_b_ff   <= b_a_ff;
         as_b_ff  <= as_a_ff;
         ab_b_ff  <= ab_a_ff;
      end
   end

   // --------------------------------------------------------------------------
   // Stage C: result alpha ar = as + ab - D(as*ab), clamped; source sums
   // --------------------------------------------------------------------------
   rsob_pkg::chan_type prod8;
   logic [8:0]         asum;
   logic [8:0]         ar9;
   rsob_pkg::chan_type ar_in;
   logic [8:0]         td_in [NC];

   assign prod8 = rsob_pkg::down16(pab_b_ff);
   assign asum  = {1'b0, as_b_ff} + {1'b0, ab_b_ff};
   assign ar9   = (asum >= {1'b0, prod8}) ? (asum - {1'b0, prod8}) : '0;
   assign ar_in = ar9[8] ? rsob_pkg::CH_MAX : ar9[7:0];

   always_comb begin
      for (int i = 0; i < NC; i++) begin
         td_in[i] = {1'b0, rsob_pkg::down16(pb_b_ff[i])}
                  + {1'b0, rsob_pkg::down16(pc_b_ff[i])};
      end
   end

   rsob_pkg::chan_type ar_c_ff;
   rsob_pkg::wide_type dvd_c_ff;
   rsob_pkg::chan_type b_c_ff  [NC];
   logic [8:0]         td_c_ff [NC];

   always_ff @(posedge clock) begin
      if (rdy[STG_C]) begin
         ar_c_ff  <= ar_in;
         dvd_c_ff <= dvd_b_ff;
         b_c_ff   <= b_b_ff;
         td_c_ff  <= td_in;
      end
   end

   // --------------------------------------------------------------------------
   // Stages Q: weight var = as*255 / ar; side data rides alongside
   // --------------------------------------------------------------------------
   rsob_pkg::chan_type var_w;

   rsob_div u_div (
      .clock    (clock),
      .stage_en (rdy[STG_Q +: NS]),
      .dividend (dvd_c_ff),
      .divisor  (ar_c_ff),
      .quotient (var_w)
   );

   rsob_pkg::chan_type ar_q_ff [NS];
   rsob_pkg::chan_type b_q_ff  [NS][NC];
   logic [8:0]         td_q_ff [NS][NC];

   for (genvar g = 0; g < NS; g++) begin : g_side
      always_ff @(posedge clock) begin
         if (rdy[STG_Q + g]) begin
            if (g == 0) begin
               ar_q_ff[g] <= ar_c_ff;
               b_q_ff[g]  <= b_c_ff;
               td_q_ff[g] <= td_c_ff;
            end else begin
               ar_q_ff[g] <= ar_q_ff[(g == 0) ? 0 : g-1];
               b_q_ff[g]  <= b_q_ff[(g == 0) ? 0 : g-1];
               td_q_ff[g] <= td_q_ff[(g == 0) ? 0 : g-1];
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stage E: backdrop and source weight products (source term wraps at 16 bits)
   // --------------------------------------------------------------------------
   rsob_pkg::wide_type pa_in [NC];
   rsob_pkg::wide_type pe_in [NC];

   always_comb begin
      logic [16:0] full;
      for (int i = 0; i < NC; i++) begin
         pa_in[i] = 16'(rsob_pkg::CH_MAX - var_w) * 16'(b_q_ff[NS-1][i]);
         full     = 17'(var_w) * 17'(td_q_ff[NS-1][i]);
         pe_in[i] = full[15:0];
      end
   end

   rsob_pkg::wide_type pa_e_ff [NC];
   rsob_pkg::wide_type pe_e_ff [NC];
   rsob_pkg::chan_type ar_e_ff;

   always_ff @(posedge clock) begin
      if (rdy[STG_E]) begin
         pa_e_ff <= pa_in;
         pe_e_ff <= pe_in;
         ar_e_ff <= ar_q_ff[NS-1];
      end
   end

   // --------------------------------------------------------------------------
   // Stage F: round, add, clamp; drop result alpha into the alpha lane
   // --------------------------------------------------------------------------
   rsob_pkg::chan_type out_in  [NC];
   rsob_pkg::chan_type out_ff  [NC];

   always_comb begin
      logic [8:0] mix;
      for (int i = 0; i < NC; i++) begin
         mix = {1'b0, rsob_pkg::down16(pa_e_ff[i])}
             + {1'b0, rsob_pkg::down16(pe_e_ff[i])};
         if (alpha_idx_ff == rsob_pkg::AIDX_W'(i)) begin
            out_in[i] = ar_e_ff;
         end else begin
            out_in[i] = mix[8] ? rsob_pkg::CH_MAX : mix[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[STG_F]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_out_c0 = out_ff[0];
   assign rsp_out_c1 = out_ff[1];
   assign rsp_out_c2 = out_ff[2];
   assign rsp_out_c3 = out_ff[3];

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   // requests held in the pipeline change only by accepts and deliveries
   `RSOB_ASSERT_NEXT(a_pipe_count, 1'b1,
      $countones(valid_ff) == $past($countones(valid_ff))
         + $past(req_valid && !req_stall) - $past(rsp_valid && !rsp_stall),
      "pipeline occupancy does not match accepted minus delivered requests")

   // back-pressure reaches the input only with every stage full and rsp stalled
   `RSOB_ASSERT_NOW(a_stall_full, req_stall, (&valid_ff) && rsp_stall,
      "req_stall raised while a stage could still move")

   // zero result alpha must give zero weight, so the source term vanishes
   `RSOB_ASSERT_NOW(a_zero_weight, valid_ff[STG_E] && (ar_e_ff == '0),
      (pe_e_ff[0] | pe_e_ff[1] | pe_e_ff[2] | pe_e_ff[3]) == '0,
      "non-zero source term with zero result alpha")

endmodule
